// File: hdl/lsq_pkg.sv
// Shared types and constants for the line segment quad expander.
package lsq_pkg;

    // Pipeline depths of the offset unit.
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 8;

    // Widths of the offset arithmetic.
    localparam int SUM_W  = 34;
    localparam int ROOT_W = 25;
    localparam int REM_W  = 27;
    localparam int NUM_W  = 34;

    // Vertex counter values.
    localparam logic [2:0] VTX_FIRST = 3'd0;
    localparam logic [2:0] VTX_LAST  = 3'd5;

    // Register map.
    localparam logic REG_HALF_WIDTH = 1'b0;
    localparam logic [7:0] HALF_WIDTH_RST = 8'd16;

    // One segment as it arrives.
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [7:0]         cr;
        logic [7:0]         cg;
        logic [7:0]         cb;
        logic [15:0]        br;
    } t_seg;

    // Endpoints and shaded colour, shared by all six vertices.
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [15:0]        o_r;
        logic [15:0]        o_g;
        logic [15:0]        o_b;
        logic [15:0]        br;
    } t_attr;

    // Data carried alongside the length and division stages.
    typedef struct packed {
        t_attr       a;
        logic [16:0] ax;
        logic [16:0] ay;
        logic        dxn;
        logic        dyn;
    } t_carry;

    // One queued segment, ready for vertex generation.
    typedef struct packed {
        t_attr             a;
        logic signed [8:0] nx;
        logic signed [8:0] ny;
    } t_quad;

endpackage

// File: hdl/line_segment_quad_expander.sv
// Top level of the line segment quad expander.
//
// Segments arrive on the s_axis channel, one transfer each; every segment
// leaves as six vertices on the m_axis channel, two triangles, the sixth
// marked with tlast and each vertex's side of the centre line in tuser.
// A segment of zero length produces no vertices.
// The APB port holds half_width (Q4.4) at address 0; write it only while
// the block is idle.
// An accepted segment reaches its first vertex through a 38-stage pipeline
// (input register, differences, squares, squared length, 25 square root
// stages, numerator, 8 division stages), the queue and the output register.
// Throughput is one vertex per cycle while segments are queued and the
// receiver is ready, set by the single output channel. A new segment can be
// taken every cycle as long as the queue has room for all segments in flight.
// When the receiver stalls, the output register holds its vertex, the queue
// fills and s_axis_tready drops once QUEUE_DEPTH segments are outstanding.
// Reset clears the pipeline, the queue and the output, and sets
// half_width to 16 (one pixel).
module line_segment_quad_expander import lsq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // start_x, start_y, end_x, end_y, color_red, color_green, color_blue, brightness
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // vert_x, vert_y, out_red, out_green, out_blue, out_alpha
    output logic [95:0]   m_axis_tdata,
    // edge_side
    output logic          m_axis_tuser,
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int CRW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0] r_half_width;
    logic [CRW-1:0] r_cred;
    logic n_acc, w_push, w_drop, w_pop, w_qvld;
    t_seg w_seg;
    t_quad w_quad, w_head;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HALF_WIDTH)) begin
            r_half_width <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HALF_WIDTH) ? {24'h0, r_half_width} : 32'h0;

    // Segments in flight or queued; a slot is reserved on accept.
    assign n_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = r_cred < CRW'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            r_cred <= r_cred + CRW'(n_acc) - CRW'(w_pop) - CRW'(w_drop);
        end
    end

    assign w_seg.sx = s_axis_tdata[15:0];
    assign w_seg.sy = s_axis_tdata[31:16];
    assign w_seg.ex = s_axis_tdata[47:32];
    assign w_seg.ey = s_axis_tdata[63:48];
    assign w_seg.cr = s_axis_tdata[71:64];
    assign w_seg.cg = s_axis_tdata[79:72];
    assign w_seg.cb = s_axis_tdata[87:80];
    assign w_seg.br = s_axis_tdata[103:88];

    lsq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (n_acc),
        .i_seg        (w_seg),
        .i_half_width (r_half_width),
        .o_push       (w_push),
        .o_quad       (w_quad),
        .o_drop       (w_drop)
    );

    lsq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_quad  (w_quad),
        .i_pop   (w_pop),
        .o_vld   (w_qvld),
        .o_quad  (w_head)
    );

    lsq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_qvld),
        .i_quad   (w_head),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// File: hdl/lsq_front.sv
// Front part: accepts segments and computes the perpendicular offset in a pipeline.
module lsq_front import lsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_seg       i_seg,
    input  logic [7:0] i_half_width,
    output logic       o_push,
    output t_quad      o_quad,
    output logic       o_drop
);

    // Stage A: input register.
    logic r_a_vld;
    t_seg r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a <= i_seg;
    end

    // Stage B: differences, magnitudes and the zero-length test.
    logic signed [16:0] n_dx, n_dy;
    logic r_b_vld, r_b_zero;
    t_seg r_b;
    logic [16:0] r_b_ax, r_b_ay;
    logic r_b_dxn, r_b_dyn;

    assign n_dx = {r_a.ex[15], r_a.ex} - {r_a.sx[15], r_a.sx};
    assign n_dy = {r_a.ey[15], r_a.ey} - {r_a.sy[15], r_a.sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b     <= r_a;
        r_b_ax  <= n_dx[16] ? 17'(~n_dx + 17'sd1) : n_dx;
        r_b_ay  <= n_dy[16] ? 17'(~n_dy + 17'sd1) : n_dy;
        r_b_dxn <= n_dx[16];
        r_b_dyn <= n_dy[16];
        r_b_zero <= (n_dx == 17'sd0) && (n_dy == 17'sd0);
    end

    // A zero-length segment leaves here and gives its queue slot back.
    assign o_drop = r_b_vld && r_b_zero;

    // Stage C: squares and colour times intensity.
    logic r_c_vld;
    t_carry r_c;
    logic [33:0] r_c_sqx, r_c_sqy;
    logic [23:0] n_pr, n_pg, n_pb;

    assign n_pr = 24'(r_b.cr * r_b.br) + 24'd128;
    assign n_pg = 24'(r_b.cg * r_b.br) + 24'd128;
    assign n_pb = 24'(r_b.cb * r_b.br) + 24'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld && !r_b_zero;
        end
        r_c.a.sx  <= r_b.sx;
        r_c.a.sy  <= r_b.sy;
        r_c.a.ex  <= r_b.ex;
        r_c.a.ey  <= r_b.ey;
        r_c.a.o_r <= n_pr[23:8];
        r_c.a.o_g <= n_pg[23:8];
        r_c.a.o_b <= n_pb[23:8];
        r_c.a.br  <= r_b.br;
        r_c.ax    <= r_b_ax;
        r_c.ay    <= r_b_ay;
        r_c.dxn   <= r_b_dxn;
        r_c.dyn   <= r_b_dyn;
        r_c_sqx   <= 34'(r_b_ax * r_b_ax);
        r_c_sqy   <= 34'(r_b_ay * r_b_ay);
    end

    // Stage D: squared length.
    logic r_d_vld;
    t_carry r_d;
    logic [SUM_W-1:0] r_d_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d   <= r_c;
        r_d_s <= r_c_sqx + r_c_sqy;
    end

    // Square root stages, one result bit per stage, of the squared length times 65536.
    logic             r_sq_vld  [SQRT_STEPS];
    t_carry           r_sq      [SQRT_STEPS];
    logic [SUM_W-1:0] r_sq_s    [SQRT_STEPS];
    logic [REM_W-1:0] r_sq_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_sq_root[SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic              in_vld;
        t_carry            in_c;
        logic [SUM_W-1:0]  in_s;
        logic [REM_W-1:0]  in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [SUM_W+15:0] rad;
        logic [1:0]        pair;
        logic [REM_W+1:0]  wide, trial;
        logic              ge;

        if (j == 0) begin : g_first
            assign in_vld  = r_d_vld;
            assign in_c    = r_d;
            assign in_s    = r_d_s;
            assign in_rem  = '0;
            assign in_root = '0;
        end else begin : g_next
            assign in_vld  = r_sq_vld[j-1];
            assign in_c    = r_sq[j-1];
            assign in_s    = r_sq_s[j-1];
            assign in_rem  = r_sq_rem[j-1];
            assign in_root = r_sq_root[j-1];
        end

        assign rad   = {in_s, 16'h0000};
        assign pair  = rad[2*(SQRT_STEPS-1-j)+1 -: 2];
        assign wide  = {in_rem, pair};
        assign trial = {2'b00, in_root, 2'b01};
        assign ge    = wide >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j] <= 1'b0;
            end else begin
                r_sq_vld[j] <= in_vld;
            end
            r_sq[j]      <= in_c;
            r_sq_s[j]    <= in_s;
            r_sq_rem[j]  <= ge ? REM_W'(wide - trial) : REM_W'(wide);
            r_sq_root[j] <= {in_root[ROOT_W-2:0], ge};
        end
    end

    // Stage N: rounded numerators of both offset components.
    logic r_n_vld;
    t_carry r_n;
    logic [NUM_W-1:0]  r_n_numx, r_n_numy;
    logic [ROOT_W-1:0] r_n_len;
    logic [ROOT_W-1:0] n_len;
    logic [24:0]       n_px, n_py;

    assign n_len = r_sq_root[SQRT_STEPS-1];
    assign n_px  = 25'(r_sq[SQRT_STEPS-1].ay * i_half_width);
    assign n_py  = 25'(r_sq[SQRT_STEPS-1].ax * i_half_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else begin
            r_n_vld <= r_sq_vld[SQRT_STEPS-1];
        end
        r_n      <= r_sq[SQRT_STEPS-1];
        r_n_len  <= n_len;
        r_n_numx <= NUM_W'({n_px, 8'h00}) + NUM_W'(n_len >> 1);
        r_n_numy <= NUM_W'({n_py, 8'h00}) + NUM_W'(n_len >> 1);
    end

    // Restoring division stages, one quotient bit per stage for both components.
    logic              r_dv_vld [DIV_STEPS];
    t_carry            r_dv     [DIV_STEPS];
    logic [ROOT_W-1:0] r_dv_len [DIV_STEPS];
    logic [NUM_W-1:0]  r_dv_rx  [DIV_STEPS];
    logic [NUM_W-1:0]  r_dv_ry  [DIV_STEPS];
    logic [7:0]        r_dv_qx  [DIV_STEPS];
    logic [7:0]        r_dv_qy  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic              in_vld;
        t_carry            in_c;
        logic [ROOT_W-1:0] in_len;
        logic [NUM_W-1:0]  in_rx, in_ry, dsr;
        logic [7:0]        in_qx, in_qy;
        logic              gex, gey;

        if (k == 0) begin : g_first
            assign in_vld = r_n_vld;
            assign in_c   = r_n;
            assign in_len = r_n_len;
            assign in_rx  = r_n_numx;
            assign in_ry  = r_n_numy;
            assign in_qx  = '0;
            assign in_qy  = '0;
        end else begin : g_next
            assign in_vld = r_dv_vld[k-1];
            assign in_c   = r_dv[k-1];
            assign in_len = r_dv_len[k-1];
            assign in_rx  = r_dv_rx[k-1];
            assign in_ry  = r_dv_ry[k-1];
            assign in_qx  = r_dv_qx[k-1];
            assign in_qy  = r_dv_qy[k-1];
        end

        assign dsr = NUM_W'(in_len) << (DIV_STEPS-1-k);
        assign gex = in_rx >= dsr;
        assign gey = in_ry >= dsr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else begin
                r_dv_vld[k] <= in_vld;
            end
            r_dv[k]     <= in_c;
            r_dv_len[k] <= in_len;
            r_dv_rx[k]  <= gex ? in_rx - dsr : in_rx;
            r_dv_ry[k]  <= gey ? in_ry - dsr : in_ry;
            r_dv_qx[k]  <= {in_qx[6:0], gex};
            r_dv_qy[k]  <= {in_qy[6:0], gey};
        end
    end

    // Signs: nx opposes dy, ny follows dx.
    logic signed [8:0] n_qx, n_qy;

    assign n_qx        = {1'b0, r_dv_qx[DIV_STEPS-1]};
    assign n_qy        = {1'b0, r_dv_qy[DIV_STEPS-1]};
    assign o_push      = r_dv_vld[DIV_STEPS-1];
    assign o_quad.a    = r_dv[DIV_STEPS-1].a;
    assign o_quad.nx   = r_dv[DIV_STEPS-1].dyn ? n_qx : -n_qx;
    assign o_quad.ny   = r_dv[DIV_STEPS-1].dxn ? -n_qy : n_qy;

endmodule

// File: hdl/lsq_fifo.sv
// Short queue of computed segments between the front and back parts.
module lsq_fifo import lsq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_quad i_quad,
    input  logic  i_pop,
    output logic  o_vld,
    output t_quad o_quad
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_quad r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    // Pointers wrap at the depth; occupancy never exceeds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_quad;
        end
    end

    assign o_vld  = r_cnt != '0;
    assign o_quad = r_mem[r_rp];

endmodule

// File: hdl/lsq_back.sv
// Back part: emits the six vertices of each queued segment through an output register.
module lsq_back import lsq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  t_quad        i_quad,
    output logic         o_pop,
    input  logic         i_tready,
    output logic         o_tvalid,
    output logic [95:0]  o_tdata,
    output logic         o_tuser,
    output logic         o_tlast
);

    logic [2:0] r_k;
    logic r_vld, r_side, r_last;
    logic [15:0] r_x, r_y, r_r, r_g, r_b, r_a;
    logic n_load, n_side, n_start;
    logic signed [15:0] n_bx, n_by;
    logic signed [16:0] n_ox, n_oy, n_sx, n_sy;

    assign n_load = i_vld && (!r_vld || i_tready);
    assign o_pop  = n_load && (r_k == VTX_LAST);

    // Vertex order p0-n, p0+n, p1-n, p0+n, p1+n, p1-n.
    always_comb begin
        unique case (r_k)
            3'd0:    begin n_side = 1'b0; n_start = 1'b1; end
            3'd1:    begin n_side = 1'b1; n_start = 1'b1; end
            3'd2:    begin n_side = 1'b0; n_start = 1'b0; end
            3'd3:    begin n_side = 1'b1; n_start = 1'b1; end
            3'd4:    begin n_side = 1'b1; n_start = 1'b0; end
            default: begin n_side = 1'b0; n_start = 1'b0; end
        endcase
    end

    assign n_bx = n_start ? i_quad.a.sx : i_quad.a.ex;
    assign n_by = n_start ? i_quad.a.sy : i_quad.a.ey;
    assign n_ox = 17'(i_quad.nx);
    assign n_oy = 17'(i_quad.ny);
    assign n_sx = n_side ? 17'(n_bx) + n_ox : 17'(n_bx) - n_ox;
    assign n_sy = n_side ? 17'(n_by) + n_oy : 17'(n_by) - n_oy;

    function automatic logic [15:0] sat16(input logic signed [16:0] v);
        if (v[16] != v[15]) begin
            return v[16] ? 16'h8000 : 16'h7FFF;
        end
        return v[15:0];
    endfunction

    // Vertex counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= VTX_FIRST;
            r_vld <= 1'b0;
        end else begin
            if (n_load) begin
                r_k   <= (r_k == VTX_LAST) ? VTX_FIRST : r_k + 3'd1;
                r_vld <= 1'b1;
            end else if (i_tready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_x    <= sat16(n_sx);
            r_y    <= sat16(n_sy);
            r_r    <= i_quad.a.o_r;
            r_g    <= i_quad.a.o_g;
            r_b    <= i_quad.a.o_b;
            r_a    <= i_quad.a.br;
            r_side <= n_side;
            r_last <= r_k == VTX_LAST;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = {r_a, r_b, r_g, r_r, r_y, r_x};
    assign o_tuser  = r_side;
    assign o_tlast  = r_last;

endmodule

// File: hdl/lsq_check.sv
// Port-level checks of the line segment quad expander, bound to the top level.
module lsq_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [95:0]   m_axis_tdata,
    input logic          m_axis_tuser,
    input logic          m_axis_tlast
);

    // A stalled vertex keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output vertex changed while stalled");

    // The sixth vertex of a segment lies on the minus side.
    a_last_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
        else $error("last vertex on the plus side");

    // Vertices of one segment follow without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a segment's vertices");

    // Output is empty right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind line_segment_quad_expander lsq_check u_check (.*);
